/* rtl/afk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_pkg
// Constants and types shared by the forward kinematics pipeline.
// ----------------------------------------------------------------------------
package afk_pkg;

  localparam int AngleWidth = 16;
  localparam int PosWidth   = 20;
  localparam int AtanEntries = 24;

  localparam logic signed [35:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [35:0] Q30TwoPi  = 36'sd6746518852;
  localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [35:0] Q30One    = 36'sd1073741824;
  localparam logic signed [35:0] CordicGain = 36'sd652032874;

  typedef logic signed [35:0] q30_t;

  // Wide accumulator for the scaled Q30 sums, which reach several hundred.
  typedef logic signed [47:0] acc_t;

  typedef struct packed {
    q30_t x;
    q30_t y;
    q30_t z;
    logic neg;
  } afk_rot_t;

  function automatic q30_t atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 36'sd843314857;
      5'd1: atan_q30 = 36'sd497837829;
      5'd2: atan_q30 = 36'sd263043837;
      5'd3: atan_q30 = 36'sd133525159;
      5'd4: atan_q30 = 36'sd67021687;
      5'd5: atan_q30 = 36'sd33543516;
      5'd6: atan_q30 = 36'sd16775851;
      5'd7: atan_q30 = 36'sd8388437;
      5'd8: atan_q30 = 36'sd4194283;
      5'd9: atan_q30 = 36'sd2097149;
      5'd10: atan_q30 = 36'sd1048576;
      5'd11: atan_q30 = 36'sd524288;
      5'd12: atan_q30 = 36'sd262144;
      5'd13: atan_q30 = 36'sd131072;
      5'd14: atan_q30 = 36'sd65536;
      5'd15: atan_q30 = 36'sd32768;
      5'd16: atan_q30 = 36'sd16384;
      5'd17: atan_q30 = 36'sd8192;
      5'd18: atan_q30 = 36'sd4096;
      5'd19: atan_q30 = 36'sd2048;
      5'd20: atan_q30 = 36'sd1024;
      5'd21: atan_q30 = 36'sd512;
      5'd22: atan_q30 = 36'sd256;
      5'd23: atan_q30 = 36'sd128;
      default: atan_q30 = '0;
    endcase
  endfunction

  // Rounded product of two Q30 values.
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [71:0] p;
    begin
      p = a * b + 72'sd536870912;
      mulq = q30_t'(p >>> 30);
    end
  endfunction

  function automatic q30_t rsh10(input acc_t v);
    rsh10 = q30_t'((v + 48'sd512) >>> 10);
  endfunction

endpackage

/* rtl/afk_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_angle_if / afk_pos_if
// Valid/ready channels for joint angle words and position words.
// ----------------------------------------------------------------------------
interface afk_angle_if;
  logic valid;
  logic ready;
  logic signed [15:0] joint_angle_1;
  logic signed [15:0] joint_angle_2;
  logic signed [15:0] joint_angle_3;
  logic signed [15:0] joint_angle_4;
  logic signed [15:0] joint_angle_5;
  modport source (output valid, joint_angle_1, joint_angle_2, joint_angle_3,
                  joint_angle_4, joint_angle_5, input ready);
  modport sink (input valid, joint_angle_1, joint_angle_2, joint_angle_3,
                joint_angle_4, joint_angle_5, output ready);
endinterface

interface afk_pos_if;
  logic valid;
  logic ready;
  logic signed [19:0] position_x;
  logic signed [19:0] position_y;
  logic signed [19:0] position_z;
  modport source (output valid, position_x, position_y, position_z, input ready);
  modport sink (input valid, position_x, position_y, position_z, output ready);
endinterface

/* rtl/afk_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_cordic_cell
// One registered CORDIC micro-rotation for five angles side by side.
// ----------------------------------------------------------------------------
module afk_cordic_cell #(
  parameter int Step = 0
) (
  input  logic clk,
  input  logic en,
  input  afk_pkg::afk_rot_t rot_in  [5],
  output afk_pkg::afk_rot_t rot_out [5]
);

  afk_pkg::afk_rot_t rot_next [5];

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      rot_next[k].neg = rot_in[k].neg;
      if (!rot_in[k].z[35]) begin
        rot_next[k].x = rot_in[k].x - (rot_in[k].y >>> Step);
        rot_next[k].y = rot_in[k].y + (rot_in[k].x >>> Step);
        rot_next[k].z = rot_in[k].z - afk_pkg::atan_q30(5'(Step));
      end else begin
        rot_next[k].x = rot_in[k].x + (rot_in[k].y >>> Step);
        rot_next[k].y = rot_in[k].y - (rot_in[k].x >>> Step);
        rot_next[k].z = rot_in[k].z + afk_pkg::atan_q30(5'(Step));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_out <= rot_next;
    end
  end

endmodule

/* rtl/arm_forward_kinematics_5joint_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_forward_kinematics_5joint_unit
// Five-joint arm forward kinematics: joint angles in, end effector x/y/z out.
// ----------------------------------------------------------------------------
// A new angle word is taken every cycle while the pipeline advances. Stages:
// angle reduction a and b, one registered cell per CORDIC step, product
// stages 1 and 2, the sum stage, the x/y product stage, the output register.
// The pipeline advances only while the output register is free or being read.
module arm_forward_kinematics_5joint_unit #(
  parameter int ANGLE_FRACTION_BITS    = 13,
  parameter int POSITION_FRACTION_BITS = 8,
  parameter int CORDIC_STEPS           = 16
) (
  input logic clk,
  input logic rst,
  afk_angle_if.sink in_ch,
  afk_pos_if.source out_ch
);

  localparam int Steps = (CORDIC_STEPS > afk_pkg::AtanEntries) ?
                         afk_pkg::AtanEntries : CORDIC_STEPS;
  localparam int Depth = Steps + 6;
  localparam int OutShift = 20 - POSITION_FRACTION_BITS;

  logic en;
  logic [Depth-1:0] vld;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_ch.valid};
    end
  end

  // Reduction: stage a is the modulo, stage b the half-pi fold.
  afk_pkg::q30_t ra [5];
  afk_pkg::afk_rot_t chain [Steps+1][5];
  logic signed [15:0] ang [5];
  assign ang[0] = in_ch.joint_angle_1;
  assign ang[1] = in_ch.joint_angle_2;
  assign ang[2] = in_ch.joint_angle_3;
  assign ang[3] = in_ch.joint_angle_4;
  assign ang[4] = in_ch.joint_angle_5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 5; k++) begin
        afk_pkg::q30_t a, b;
        a = afk_pkg::q30_t'(ang[k]) <<< (30 - ANGLE_FRACTION_BITS);
        // |a| < 6*2pi for any legal scale; subtract multiples by comparison.
        b = a;
        if (b >= 4 * afk_pkg::Q30TwoPi) b = b - 4 * afk_pkg::Q30TwoPi;
        else if (b <= -4 * afk_pkg::Q30TwoPi) b = b + 4 * afk_pkg::Q30TwoPi;
        if (b >= 2 * afk_pkg::Q30TwoPi) b = b - 2 * afk_pkg::Q30TwoPi;
        else if (b <= -2 * afk_pkg::Q30TwoPi) b = b + 2 * afk_pkg::Q30TwoPi;
        if (b >= afk_pkg::Q30TwoPi) b = b - afk_pkg::Q30TwoPi;
        else if (b <= -afk_pkg::Q30TwoPi) b = b + afk_pkg::Q30TwoPi;
        if (b > afk_pkg::Q30Pi) b = b - afk_pkg::Q30TwoPi;
        if (b < -afk_pkg::Q30Pi) b = b + afk_pkg::Q30TwoPi;
        ra[k] <= b;
      end
      for (int k = 0; k < 5; k++) begin
        chain[0][k].x <= afk_pkg::CordicGain;
        chain[0][k].y <= '0;
        if (ra[k] > afk_pkg::Q30HalfPi) begin
          chain[0][k].z <= ra[k] - afk_pkg::Q30Pi;
          chain[0][k].neg <= 1'b1;
        end else if (ra[k] < -afk_pkg::Q30HalfPi) begin
          chain[0][k].z <= ra[k] + afk_pkg::Q30Pi;
          chain[0][k].neg <= 1'b1;
        end else begin
          chain[0][k].z <= ra[k];
          chain[0][k].neg <= 1'b0;
        end
      end
    end
  end

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    afk_cordic_cell #(.Step(g)) u_cell (
      .clk(clk), .en(en), .rot_in(chain[g]), .rot_out(chain[g+1])
    );
  end

  afk_pkg::q30_t s [5];
  afk_pkg::q30_t c [5];
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      s[k] = chain[Steps][k].neg ? -chain[Steps][k].y : chain[Steps][k].y;
      c[k] = chain[Steps][k].neg ? -chain[Steps][k].x : chain[Steps][k].x;
    end
  end

  // Product stage 1.
  afk_pkg::q30_t m_c2c3, m_s2s3, m_s3c2, m_c3s2, m_c5c4, m_c5s4;
  afk_pkg::q30_t p1_s1, p1_c1, p1_s2, p1_c2, p1_s5;
  always_ff @(posedge clk) begin
    if (en) begin
      m_c2c3 <= afk_pkg::mulq(c[1], c[2]);
      m_s2s3 <= afk_pkg::mulq(s[1], s[2]);
      m_s3c2 <= afk_pkg::mulq(s[2], c[1]);
      m_c3s2 <= afk_pkg::mulq(c[2], s[1]);
      m_c5c4 <= afk_pkg::mulq(c[4], c[3]);
      m_c5s4 <= afk_pkg::mulq(c[4], s[3]);
      p1_s1 <= s[0]; p1_c1 <= c[0]; p1_s2 <= s[1]; p1_c2 <= c[1]; p1_s5 <= s[4];
    end
  end

  afk_pkg::q30_t q, p;
  assign q = m_c2c3 - m_s2s3;
  assign p = m_s3c2 + m_c3s2;

  // Product stage 2.
  afk_pkg::q30_t q2, p2, m_s5p, m_c5c4q, m_c5c4p, m_s5q, m_ws1, m_wc1;
  afk_pkg::q30_t p2_s1, p2_c1, p2_s2, p2_c2;
  always_ff @(posedge clk) begin
    if (en) begin
      q2 <= q; p2 <= p;
      m_s5p <= afk_pkg::mulq(p1_s5, p);
      m_c5c4q <= afk_pkg::mulq(m_c5c4, q);
      m_c5c4p <= afk_pkg::mulq(m_c5c4, p);
      m_s5q <= afk_pkg::mulq(p1_s5, q);
      m_ws1 <= afk_pkg::mulq(m_c5s4, p1_s1);
      m_wc1 <= afk_pkg::mulq(m_c5s4, p1_c1);
      p2_s1 <= p1_s1; p2_c1 <= p1_c1; p2_s2 <= p1_s2; p2_c2 <= p1_c2;
    end
  end

  // Sum stage: R rounded to Q20, z and the side terms.
  afk_pkg::q30_t r20, zq20, tx, ty, p3_s1, p3_c1;
  always_ff @(posedge clk) begin
    if (en) begin
      r20 <= afk_pkg::rsh10(56 * (afk_pkg::acc_t'(afk_pkg::Q30One) + afk_pkg::acc_t'(q2)
                                  + afk_pkg::acc_t'(m_s5p) + afk_pkg::acc_t'(m_c5c4q))
                            + 170 * afk_pkg::acc_t'(p2) + 200 * afk_pkg::acc_t'(p2_c2));
      zq20 <= afk_pkg::rsh10(200 * afk_pkg::acc_t'(p2_s2) - 170 * afk_pkg::acc_t'(q2)
                             + 56 * afk_pkg::acc_t'(m_c5c4p)
                             - 56 * afk_pkg::acc_t'(m_s5q)
                             + 56 * afk_pkg::acc_t'(p2)
                             + 280 * afk_pkg::acc_t'(afk_pkg::Q30One));
      tx <= afk_pkg::rsh10(56 * afk_pkg::acc_t'(m_ws1));
      ty <= afk_pkg::rsh10(56 * afk_pkg::acc_t'(m_wc1));
      p3_s1 <= p2_s1; p3_c1 <= p2_c1;
    end
  end

  afk_pkg::q30_t xq20, yq20, zq20b;
  always_ff @(posedge clk) begin
    if (en) begin
      xq20 <= afk_pkg::mulq(p3_c1, r20) + tx;
      yq20 <= afk_pkg::mulq(p3_s1, r20) - ty;
      zq20b <= zq20;
    end
  end

  function automatic logic signed [19:0] to_out(input afk_pkg::q30_t v);
    afk_pkg::q30_t t;
    begin
      if (OutShift == 0) t = v;
      else t = (v + (36'sd1 <<< (OutShift - 1))) >>> OutShift;
      if (t > 36'sd524287) to_out = 20'sd524287;
      else if (t < -36'sd524288) to_out = -20'sd524288;
      else to_out = t[19:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= vld[Depth-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.position_x <= to_out(xq20);
      out_ch.position_y <= to_out(yq20);
      out_ch.position_z <= to_out(zq20b);
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result word dropped while stalled");
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output");
  a_pipe_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives joint angle words into the forward kinematics unit and compares
// every position word with a bit-exact predictor of the pipeline.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int AngleFrac = 13;
  localparam int PosFrac   = 8;
  localparam int Steps     = 16;
  localparam int Latency   = Steps + 7;
  localparam longint TwoPi  = 64'sd6746518852;
  localparam longint Pi     = 64'sd3373259426;
  localparam longint HalfPi = 64'sd1686629713;
  localparam longint One    = 64'sd1073741824;
  localparam longint Gain   = 64'sd652032874;
  localparam longint OutMax = 64'sd524287;
  localparam longint OutMin = -64'sd524288;

  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } pos_t;

  logic clk;
  logic rst;

  afk_angle_if angle_ch ();
  afk_pos_if pos_ch ();

  arm_forward_kinematics_5joint_unit #(
    .ANGLE_FRACTION_BITS(AngleFrac),
    .POSITION_FRACTION_BITS(PosFrac),
    .CORDIC_STEPS(Steps)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(angle_ch.sink),
    .out_ch(pos_ch.source)
  );

  pos_t expected_pos[$];
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int mismatches;
  int words_sent;
  int words_checked;
  bit done;

  longint atan_tab[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) begin
      return v;
    end
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rnd_shift(a * b, 30);
  endfunction

  function automatic void joint_sin_cos(logic signed [15:0] ang, output longint s,
                                        output longint c);
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit flip;
    int n;
    a = longint'(ang) * (64'sd1 <<< (30 - AngleFrac));
    a = a % TwoPi;
    if (a > Pi) begin
      a -= TwoPi;
    end
    if (a < -Pi) begin
      a += TwoPi;
    end
    flip = 1'b0;
    if (a > HalfPi) begin
      a -= Pi;
      flip = 1'b1;
    end else if (a < -HalfPi) begin
      a += Pi;
      flip = 1'b1;
    end
    x = Gain;
    y = 0;
    z = a;
    n = (Steps > 24) ? 24 : Steps;
    for (int i = 0; i < n; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic logic signed [19:0] to_pos(longint v20);
    longint v;
    v = rnd_shift(v20, 20 - PosFrac);
    if (v > OutMax) begin
      v = OutMax;
    end
    if (v < OutMin) begin
      v = OutMin;
    end
    return v[19:0];
  endfunction

  function automatic pos_t arm_position(logic signed [15:0] a1, logic signed [15:0] a2,
                                        logic signed [15:0] a3, logic signed [15:0] a4,
                                        logic signed [15:0] a5);
    longint s1, c1, s2, c2, s3, c3, s4, c4, s5, c5;
    longint q, p, c54, u, r, r20, w, px, py, pz;
    pos_t res;
    joint_sin_cos(a1, s1, c1);
    joint_sin_cos(a2, s2, c2);
    joint_sin_cos(a3, s3, c3);
    joint_sin_cos(a4, s4, c4);
    joint_sin_cos(a5, s5, c5);
    q = qmul(c2, c3) - qmul(s2, s3);
    p = qmul(s3, c2) + qmul(c3, s2);
    c54 = qmul(c5, c4);
    u = One + q + qmul(s5, p) + qmul(c54, q);
    r = 56 * u + 170 * p + 200 * c2;
    r20 = rnd_shift(r, 10);
    w = qmul(c5, s4);
    px = qmul(c1, r20) + rnd_shift(56 * qmul(w, s1), 10);
    py = qmul(s1, r20) - rnd_shift(56 * qmul(w, c1), 10);
    pz = rnd_shift(200 * s2 - 170 * q + 56 * qmul(c54, p) - 56 * qmul(s5, q)
                   + 56 * p + 280 * One, 10);
    res.x = to_pos(px);
    res.y = to_pos(py);
    res.z = to_pos(pz);
    return res;
  endfunction

  task automatic send_angles(logic signed [15:0] a1, logic signed [15:0] a2,
                             logic signed [15:0] a3, logic signed [15:0] a4,
                             logic signed [15:0] a5);
    while ($urandom_range(99) < send_idle_pct) begin
      angle_ch.valid <= 1'b0;
      @(posedge clk);
    end
    angle_ch.valid <= 1'b1;
    angle_ch.joint_angle_1 <= a1;
    angle_ch.joint_angle_2 <= a2;
    angle_ch.joint_angle_3 <= a3;
    angle_ch.joint_angle_4 <= a4;
    angle_ch.joint_angle_5 <= a5;
    @(posedge clk);
    while (!angle_ch.ready) begin
      @(posedge clk);
    end
    expected_pos.insert(expected_pos.size(), arm_position(a1, a2, a3, a4, a5));
    words_sent++;
  endtask

  task automatic release_sender();
    angle_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(2 * 25736)) - 25736);
      2: return 16'($signed($urandom_range(400)) - 200);
      default: return 16'($signed($urandom_range(2 * 12868)) - 12868);
    endcase
  endfunction

  task automatic send_random(int count);
    for (int n = 0; n < count; n++) begin
      send_angles(rand_angle(), rand_angle(), rand_angle(), rand_angle(), rand_angle());
    end
    release_sender();
  endtask

  task automatic wait_drained();
    while (expected_pos.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_directed();
    logic signed [15:0] edges[8];
    edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
              16'sh7fff, 16'sh8000, 16'sd1};
    send_angles(0, 0, 0, 0, 0);
    send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
    send_angles(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555);
    send_angles(16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    for (int k = 0; k < 8; k++) begin
      send_angles(edges[k], edges[(k + 1) % 8], edges[(k + 2) % 8],
                  edges[(k + 3) % 8], edges[(k + 4) % 8]);
    end
    send_angles(0, 12868, 0, 0, 0);
    send_angles(0, -12868, 0, 0, 0);
    send_angles(12868, 12868, -12868, 12868, 0);
    send_angles(0, 0, 25736, 0, 12868);
    release_sender();
    wait_drained();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    send_random(count);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 3 * Latency;
    send_random(60);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    angle_ch.valid = 1'b0;
    angle_ch.joint_angle_1 = '0;
    angle_ch.joint_angle_2 = '0;
    angle_ch.joint_angle_3 = '0;
    angle_ch.joint_angle_4 = '0;
    angle_ch.joint_angle_5 = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(0, 0, 60);
    test_random_phase(58, 0, 90);
    test_random_phase(0, 58, 90);
    test_random_phase(34, 34, 90);
    test_random_phase(0, 0, 30);
    test_backpressure();
    repeat (Latency + 5) @(posedge clk);
    $display("Sent %0d angle words and checked %0d position words", words_sent,
             words_checked);
    $display("Phases: directed edges, free flow, sender gaps, receiver stalls, both, hold-off");
    done = 1'b1;
    if (mismatches == 0 && expected_pos.size() == 0) begin
      $display("arm_forward_kinematics_5joint_unit verification clean");
    end else begin
      $display("arm_forward_kinematics_5joint_unit verification failed");
    end
    $finish;
  end

  initial begin
    pos_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        pos_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      pos_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pos_t want;
    if (!rst && pos_ch.valid && pos_ch.ready) begin
      if (expected_pos.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected position word x=%0d y=%0d z=%0d", pos_ch.position_x,
                   pos_ch.position_y, pos_ch.position_z);
        end
      end else begin
        want = expected_pos.pop_front();
        words_checked++;
        if (want.x !== pos_ch.position_x || want.y !== pos_ch.position_y ||
            want.z !== pos_ch.position_z) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Position mismatch: expected (%0d, %0d, %0d), got (%0d, %0d, %0d)",
                     want.x, want.y, want.z, pos_ch.position_x, pos_ch.position_y,
                     pos_ch.position_z);
          end
        end
      end
    end
  end

  initial begin
    #(20ms);
    if (!done) begin
      $display("arm_forward_kinematics_5joint_unit verification failed");
      $finish;
    end
  end

endmodule
